@@ src/lrp_pkg.sv @@
// Shared types, codes and defaults for the LR shift-reduce parse engine.
package lrp_pkg;

    // Default sizing of the tables and the state stack
    localparam int DEF_NUM_STATES       = 256;
    localparam int DEF_NUM_TERMINALS    = 64;
    localparam int DEF_NUM_NONTERMINALS = 32;
    localparam int DEF_NUM_PRODUCTIONS  = 128;
    localparam int DEF_STACK_DEPTH      = 256;

    // Configuration registers
    localparam logic [15:0] STEP_LIMIT_RESET = 16'd10000;
    localparam logic [0:0]  CFG_STEP_LIMIT   = 1'd0;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_BEGIN   = 3'd0,
        CMD_WR_ACT  = 3'd1,
        CMD_WR_GOTO = 3'd2,
        CMD_WR_PROD = 3'd3,
        CMD_TOKEN   = 3'd4
    } t_cmd;

    // Classified operation handed to the back end
    typedef enum logic [2:0] {
        OP_BEGIN,
        OP_WR_ACT,
        OP_WR_GOTO,
        OP_WR_PROD,
        OP_TOKEN,
        OP_IGNORE
    } t_op;

    typedef enum logic [1:0] {
        KIND_ERROR  = 2'd0,
        KIND_SHIFT  = 2'd1,
        KIND_REDUCE = 2'd2,
        KIND_ACCEPT = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        OUT_OK        = 4'd0,
        OUT_SHIFT     = 4'd1,
        OUT_ACCEPT    = 4'd2,
        OUT_SYNTAX    = 4'd3,
        OUT_UNDERFLOW = 4'd4,
        OUT_NOGOTO    = 4'd5,
        OUT_LIMIT     = 4'd6,
        OUT_IGNORED   = 4'd7,
        OUT_OVERFLOW  = 4'd8
    } t_outcome;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_ACT,
        S_PROD,
        S_POP,
        S_GOTO
    } t_bk_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] state_idx;
        logic [5:0] symbol;
        logic [1:0] kind;
        logic [7:0] value;
        logic [6:0] prod_idx;
        logic [3:0] rhs_len;
    } t_item;

    // Back end status seen by the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bk_status;

    typedef struct packed {
        logic        done;
        t_outcome    outcome;
        logic [15:0] reds;
        logic [7:0]  top;
        logic [8:0]  depth;
    } t_result;

endpackage

@@ src/lrp_front.sv @@
// Front end: takes command transactions, classifies them and queues them for the back end.
module lrp_front #(
    parameter int NUM_STATES       = lrp_pkg::DEF_NUM_STATES,
    parameter int NUM_TERMINALS    = lrp_pkg::DEF_NUM_TERMINALS,
    parameter int NUM_NONTERMINALS = lrp_pkg::DEF_NUM_NONTERMINALS,
    parameter int NUM_PRODUCTIONS  = lrp_pkg::DEF_NUM_PRODUCTIONS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_cmd,
    input  logic [7:0]          i_state_index,
    input  logic [5:0]          i_symbol,
    input  logic [1:0]          i_entry_kind,
    input  logic [7:0]          i_entry_value,
    input  logic [6:0]          i_production_index,
    input  logic [3:0]          i_rhs_length,
    input  lrp_pkg::t_bk_status i_status,
    output logic                o_q_valid,
    output lrp_pkg::t_item      o_q_item
);
    import lrp_pkg::*;

    t_item               r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_CW-1:0] r_cnt;
    logic                accept;
    logic                st_ok;
    logic                term_ok;
    logic                nonterm_ok;
    logic                prod_ok;
    t_item               item;

    assign busy   = (int'(r_cnt) == QUEUE_DEPTH) || i_status.clearing;
    assign accept = start && !busy;

    // Range checks against table sizes
    assign st_ok      = int'(i_state_index) < NUM_STATES;
    assign term_ok    = int'(i_symbol) < NUM_TERMINALS;
    assign nonterm_ok = int'(i_symbol) < NUM_NONTERMINALS;
    assign prod_ok    = int'(i_production_index) < NUM_PRODUCTIONS;

    // Classify the command; out-of-range writes and unknown codes are ignored
    always_comb begin
        item.state_idx = i_state_index;
        item.symbol    = i_symbol;
        item.kind      = i_entry_kind;
        item.value     = i_entry_value;
        item.prod_idx  = i_production_index;
        item.rhs_len   = i_rhs_length;
        case (i_cmd)
            CMD_BEGIN:   item.op = OP_BEGIN;
            CMD_WR_ACT:  item.op = (st_ok && term_ok) ? OP_WR_ACT : OP_IGNORE;
            CMD_WR_GOTO: item.op = (st_ok && nonterm_ok) ? OP_WR_GOTO : OP_IGNORE;
            CMD_WR_PROD: item.op = (prod_ok && nonterm_ok) ? OP_WR_PROD : OP_IGNORE;
            CMD_TOKEN:   item.op = OP_TOKEN;
            default:     item.op = OP_IGNORE;
        endcase
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= item;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_status.pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QUEUE_CW'(accept) - QUEUE_CW'(i_status.pop);
        end
    end

    assign o_q_valid = r_cnt != '0;
    assign o_q_item  = r_q[r_rp];

endmodule

@@ src/lrp_back.sv @@
// Back end: owns the parse tables and state stack and runs each queued command.
module lrp_back #(
    parameter int NUM_STATES       = lrp_pkg::DEF_NUM_STATES,
    parameter int NUM_TERMINALS    = lrp_pkg::DEF_NUM_TERMINALS,
    parameter int NUM_NONTERMINALS = lrp_pkg::DEF_NUM_NONTERMINALS,
    parameter int NUM_PRODUCTIONS  = lrp_pkg::DEF_NUM_PRODUCTIONS,
    parameter int STACK_DEPTH      = lrp_pkg::DEF_STACK_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  lrp_pkg::t_item      i_q_item,
    input  logic [15:0]         i_step_limit,
    output lrp_pkg::t_bk_status o_status,
    output lrp_pkg::t_result    o_result
);
    import lrp_pkg::*;

    localparam int ACT_DEPTH  = NUM_STATES * NUM_TERMINALS;
    localparam int GOTO_DEPTH = NUM_STATES * NUM_NONTERMINALS;
    localparam int ACT_AW     = $clog2(ACT_DEPTH);
    localparam int GOTO_AW    = (GOTO_DEPTH > 1) ? $clog2(GOTO_DEPTH) : 1;
    localparam int PROD_AW    = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
    localparam int STK_AW     = $clog2(STACK_DEPTH);
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);
    localparam int CLR_DEPTH  = (ACT_DEPTH > GOTO_DEPTH) ? ACT_DEPTH : GOTO_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

    // Memories
    logic [9:0] act_mem  [ACT_DEPTH];
    logic [8:0] goto_mem [GOTO_DEPTH];
    logic [9:0] prod_mem [NUM_PRODUCTIONS];
    logic [7:0] stk_mem  [STACK_DEPTH];

    logic               act_we;
    logic [ACT_AW-1:0]  act_waddr;
    logic [9:0]         act_wdata;
    logic [ACT_AW-1:0]  act_raddr;
    logic [9:0]         r_act_rd;
    logic               goto_we;
    logic [GOTO_AW-1:0] goto_waddr;
    logic [8:0]         goto_wdata;
    logic [GOTO_AW-1:0] goto_raddr;
    logic [8:0]         r_goto_rd;
    logic               prod_we;
    logic [PROD_AW-1:0] prod_waddr;
    logic [9:0]         prod_wdata;
    logic [PROD_AW-1:0] prod_raddr;
    logic [9:0]         r_prod_rd;
    logic               stk_we;
    logic [STK_AW-1:0]  stk_waddr;
    logic [7:0]         stk_wdata;
    logic [STK_AW-1:0]  stk_raddr;
    logic [7:0]         r_stk_rd;

    // Control and datapath registers
    t_bk_state   r_state, n_state;
    logic [CLR_W-1:0] r_clr_cnt, n_clr_cnt;
    logic [SP_W-1:0]  r_sp, n_sp;
    logic [7:0]  r_top, n_top;
    logic [15:0] r_step, n_step;
    logic        r_finished, n_finished;
    logic [5:0]  r_tok, n_tok;
    logic [15:0] r_reds, n_reds;
    logic [5:0]  r_lhs, n_lhs;
    logic        r_cell_zero, n_cell_zero;
    logic        r_prod_zero, n_prod_zero;
    logic        r_goto_zero, n_goto_zero;
    t_result     r_res, n_res;
    logic        pop;

    // Decoded lookups
    t_kind       act_kind;
    logic [7:0]  act_val;
    logic [3:0]  prod_len;
    logic [5:0]  prod_lhs;
    logic        limit_hit;
    logic        stk_full;
    logic        underflow;
    logic        goto_valid;
    logic [SP_W-1:0] pop_sp;

    assign act_kind   = r_cell_zero ? KIND_ERROR : t_kind'(r_act_rd[9:8]);
    assign act_val    = r_act_rd[7:0];
    assign prod_len   = r_prod_zero ? 4'd0 : r_prod_rd[3:0];
    assign prod_lhs   = r_prod_zero ? 6'd0 : r_prod_rd[9:4];
    assign limit_hit  = r_step >= i_step_limit;
    assign stk_full   = int'(r_sp) >= STACK_DEPTH;
    assign underflow  = (r_sp == '0) || (int'(r_sp) - 1 < int'(prod_len));
    assign goto_valid = !r_goto_zero && r_goto_rd[8];
    assign pop_sp     = r_sp - SP_W'(prod_len);

    // Memory ports: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (act_we) begin
            act_mem[act_waddr] <= act_wdata;
        end
        r_act_rd <= act_mem[act_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (goto_we) begin
            goto_mem[goto_waddr] <= goto_wdata;
        end
        r_goto_rd <= goto_mem[goto_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (prod_we) begin
            prod_mem[prod_waddr] <= prod_wdata;
        end
        r_prod_rd <= prod_mem[prod_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= stk_mem[stk_raddr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_cnt == CLR_LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (i_q_valid && i_q_item.op == OP_TOKEN && !r_finished) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = limit_hit ? S_IDLE : S_ACT;
            S_ACT:   n_state = (act_kind == KIND_REDUCE) ? S_PROD : S_IDLE;
            S_PROD:  n_state = underflow ? S_IDLE : S_POP;
            S_POP:   n_state = S_GOTO;
            S_GOTO:  n_state = (!goto_valid || stk_full) ? S_IDLE : S_CHECK;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and results
    always_comb begin
        n_clr_cnt   = r_clr_cnt;
        n_sp        = r_sp;
        n_top       = r_top;
        n_step      = r_step;
        n_finished  = r_finished;
        n_tok       = r_tok;
        n_reds      = r_reds;
        n_lhs       = r_lhs;
        n_cell_zero = r_cell_zero;
        n_prod_zero = r_prod_zero;
        n_goto_zero = r_goto_zero;
        n_res       = r_res;
        n_res.done  = 1'b0;
        pop         = 1'b0;
        act_we      = 1'b0;
        act_waddr   = ACT_AW'(i_q_item.state_idx) * ACT_AW'(NUM_TERMINALS)
                    + ACT_AW'(i_q_item.symbol);
        act_wdata   = {i_q_item.kind, i_q_item.value};
        act_raddr   = ACT_AW'(r_top) * ACT_AW'(NUM_TERMINALS) + ACT_AW'(r_tok);
        goto_we     = 1'b0;
        goto_waddr  = GOTO_AW'(i_q_item.state_idx) * GOTO_AW'(NUM_NONTERMINALS)
                    + GOTO_AW'(i_q_item.symbol);
        goto_wdata  = {i_q_item.kind != 2'd0, i_q_item.value};
        goto_raddr  = GOTO_AW'(r_stk_rd) * GOTO_AW'(NUM_NONTERMINALS) + GOTO_AW'(r_lhs);
        prod_we     = 1'b0;
        prod_waddr  = PROD_AW'(i_q_item.prod_idx);
        prod_wdata  = {i_q_item.symbol, i_q_item.rhs_len};
        prod_raddr  = PROD_AW'(act_val);
        stk_we      = 1'b0;
        stk_waddr   = r_sp[STK_AW-1:0];
        stk_wdata   = act_val;
        stk_raddr   = STK_AW'(pop_sp - SP_W'(1));

        case (r_state)
            // Sweep both tables to their reset contents
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (int'(r_clr_cnt) < ACT_DEPTH) begin
                    act_we    = 1'b1;
                    act_waddr = ACT_AW'(r_clr_cnt);
                    act_wdata = '0;
                end
                if (int'(r_clr_cnt) < GOTO_DEPTH) begin
                    goto_we    = 1'b1;
                    goto_waddr = GOTO_AW'(r_clr_cnt);
                    goto_wdata = '0;
                end
            end
            // Take the next queued command
            S_IDLE: begin
                if (i_q_valid) begin
                    pop    = 1'b1;
                    n_reds = '0;
                    case (i_q_item.op)
                        OP_BEGIN: begin
                            stk_we        = 1'b1;
                            stk_waddr     = '0;
                            stk_wdata     = '0;
                            n_sp          = SP_W'(1);
                            n_top         = '0;
                            n_step        = '0;
                            n_finished    = 1'b0;
                            n_res.done    = 1'b1;
                            n_res.outcome = OUT_OK;
                        end
                        OP_WR_ACT: begin
                            act_we        = 1'b1;
                            n_res.done    = 1'b1;
                            n_res.outcome = OUT_OK;
                        end
                        OP_WR_GOTO: begin
                            goto_we       = 1'b1;
                            n_res.done    = 1'b1;
                            n_res.outcome = OUT_OK;
                        end
                        OP_WR_PROD: begin
                            prod_we       = 1'b1;
                            n_res.done    = 1'b1;
                            n_res.outcome = OUT_OK;
                        end
                        OP_TOKEN: begin
                            n_tok = i_q_item.symbol;
                            if (r_finished) begin
                                n_res.done    = 1'b1;
                                n_res.outcome = OUT_IGNORED;
                            end
                        end
                        default: begin
                            n_res.done    = 1'b1;
                            n_res.outcome = OUT_IGNORED;
                        end
                    endcase
                end
            end
            // Step budget, then ACTION lookup
            S_CHECK: begin
                if (limit_hit) begin
                    n_finished    = 1'b1;
                    n_res.done    = 1'b1;
                    n_res.outcome = OUT_LIMIT;
                end else begin
                    n_step      = r_step + 16'd1;
                    n_cell_zero = !(int'(r_top) < NUM_STATES && int'(r_tok) < NUM_TERMINALS);
                end
            end
            S_ACT: begin
                case (act_kind)
                    KIND_ACCEPT: begin
                        n_finished    = 1'b1;
                        n_res.done    = 1'b1;
                        n_res.outcome = OUT_ACCEPT;
                    end
                    KIND_SHIFT: begin
                        n_res.done = 1'b1;
                        if (stk_full) begin
                            n_finished    = 1'b1;
                            n_res.outcome = OUT_OVERFLOW;
                        end else begin
                            stk_we        = 1'b1;
                            n_sp          = r_sp + SP_W'(1);
                            n_top         = act_val;
                            n_res.outcome = OUT_SHIFT;
                        end
                    end
                    KIND_REDUCE: begin
                        n_prod_zero = !(int'(act_val) < NUM_PRODUCTIONS);
                    end
                    default: begin
                        n_finished    = 1'b1;
                        n_res.done    = 1'b1;
                        n_res.outcome = OUT_SYNTAX;
                    end
                endcase
            end
            // Pop the rule and fetch the uncovered state
            S_PROD: begin
                if (underflow) begin
                    n_finished    = 1'b1;
                    n_res.done    = 1'b1;
                    n_res.outcome = OUT_UNDERFLOW;
                end else begin
                    n_sp  = pop_sp;
                    n_lhs = prod_lhs;
                end
            end
            S_POP: begin
                n_top       = r_stk_rd;
                n_goto_zero = !(int'(r_stk_rd) < NUM_STATES && int'(r_lhs) < NUM_NONTERMINALS);
            end
            // Push the GOTO target
            S_GOTO: begin
                if (!goto_valid) begin
                    n_finished    = 1'b1;
                    n_res.done    = 1'b1;
                    n_res.outcome = OUT_NOGOTO;
                end else if (stk_full) begin
                    n_finished    = 1'b1;
                    n_res.done    = 1'b1;
                    n_res.outcome = OUT_OVERFLOW;
                end else begin
                    stk_we    = 1'b1;
                    stk_wdata = r_goto_rd[7:0];
                    n_sp      = r_sp + SP_W'(1);
                    n_top     = r_goto_rd[7:0];
                    if (r_reds != 16'hFFFF) begin
                        n_reds = r_reds + 16'd1;
                    end
                end
            end
            default: ;
        endcase

        if (n_res.done) begin
            n_res.reds  = n_reds;
            n_res.top   = (n_sp == '0) ? 8'd0 : n_top;
            n_res.depth = 9'(n_sp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_cnt  <= '0;
            r_sp       <= '0;
            r_top      <= '0;
            r_step     <= '0;
            r_finished <= 1'b1;
            r_res      <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_sp       <= n_sp;
            r_top      <= n_top;
            r_step     <= n_step;
            r_finished <= n_finished;
            r_res      <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok       <= n_tok;
        r_reds      <= n_reds;
        r_lhs       <= n_lhs;
        r_cell_zero <= n_cell_zero;
        r_prod_zero <= n_prod_zero;
        r_goto_zero <= n_goto_zero;
    end

    assign o_status.pop      = pop;
    assign o_status.clearing = r_state == S_CLEAR;
    assign o_result          = r_res;

endmodule

@@ src/lr_shift_reduce_parse_engine_unit.sv @@
// Top level of the table-driven LR shift-reduce parse engine.
// After reset the engine sweeps its ACTION and GOTO tables to empty, stepping through
// NUM_STATES*max(NUM_TERMINALS,NUM_NONTERMINALS) addresses (16384 at the defaults);
// busy stays high until then. A command transaction is taken when start is high and
// busy is low, and enters a two-entry queue; busy also rises while that queue is full.
// Every command gives exactly one result, shown for one cycle with o_done; the
// receiver cannot stall it. Table writes, begin and ignored commands give their result
// in the cycle after they leave the queue. A token passes through a step check and an
// ACTION read, and each reduction through a step check, ACTION read, production read,
// stack read, GOTO read and push, since each step waits on the registered read of
// the previous memory.
module lr_shift_reduce_parse_engine_unit #(
    parameter int NUM_STATES       = lrp_pkg::DEF_NUM_STATES,
    parameter int NUM_TERMINALS    = lrp_pkg::DEF_NUM_TERMINALS,
    parameter int NUM_NONTERMINALS = lrp_pkg::DEF_NUM_NONTERMINALS,
    parameter int NUM_PRODUCTIONS  = lrp_pkg::DEF_NUM_PRODUCTIONS,
    parameter int STACK_DEPTH      = lrp_pkg::DEF_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_state_index,
    input  logic [5:0]  i_symbol,
    input  logic [1:0]  i_entry_kind,
    input  logic [7:0]  i_entry_value,
    input  logic [6:0]  i_production_index,
    input  logic [3:0]  i_rhs_length,
    output logic        o_done,
    output logic [3:0]  o_outcome,
    output logic [15:0] o_reductions_done,
    output logic [7:0]  o_top_state,
    output logic [8:0]  o_stack_depth,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import lrp_pkg::*;

    logic        step_limit_we;
    logic [15:0] r_step_limit;
    logic        q_valid;
    t_item       q_item;
    t_bk_status  status;
    t_result     result;

    // Configuration; the end marker is parsed as an ordinary token and needs no storage
    assign step_limit_we = i_cfg_we && (i_cfg_idx == CFG_STEP_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= STEP_LIMIT_RESET;
        end else if (step_limit_we) begin
            r_step_limit <= i_cfg_data;
        end
    end

    lrp_front #(
        .NUM_STATES       (NUM_STATES),
        .NUM_TERMINALS    (NUM_TERMINALS),
        .NUM_NONTERMINALS (NUM_NONTERMINALS),
        .NUM_PRODUCTIONS  (NUM_PRODUCTIONS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cmd              (i_cmd),
        .i_state_index      (i_state_index),
        .i_symbol           (i_symbol),
        .i_entry_kind       (i_entry_kind),
        .i_entry_value      (i_entry_value),
        .i_production_index (i_production_index),
        .i_rhs_length       (i_rhs_length),
        .i_status           (status),
        .o_q_valid          (q_valid),
        .o_q_item           (q_item)
    );

    lrp_back #(
        .NUM_STATES       (NUM_STATES),
        .NUM_TERMINALS    (NUM_TERMINALS),
        .NUM_NONTERMINALS (NUM_NONTERMINALS),
        .NUM_PRODUCTIONS  (NUM_PRODUCTIONS),
        .STACK_DEPTH      (STACK_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .i_step_limit (r_step_limit),
        .o_status     (status),
        .o_result     (result)
    );

    assign o_done            = result.done;
    assign o_outcome         = result.outcome;
    assign o_reductions_done = result.reds;
    assign o_top_state       = result.top;
    assign o_stack_depth     = result.depth;

endmodule

@@ src/lrp_checker.sv @@
// Port-level checks for the parse engine, bound to the top level.
module lrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_done,
    input logic [3:0]  o_outcome,
    input logic [15:0] o_reductions_done,
    input logic [7:0]  o_top_state,
    input logic [8:0]  o_stack_depth
);
    import lrp_pkg::*;

    // Reset starts the table sweep and drops any pending result
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_done)
        else $error("busy/done wrong after reset");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_outcome <= OUT_OVERFLOW)
        else $error("outcome code out of range");

    // An empty stack reports state zero on top
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_stack_depth == 9'd0 |-> o_top_state == 8'd0)
        else $error("nonzero top with empty stack");

    // Writes, begin and ignored items perform no reductions
    a_no_reds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_outcome == OUT_OK || o_outcome == OUT_IGNORED)
            |-> o_reductions_done == 16'd0)
        else $error("reductions reported for a non-token transaction");

endmodule

bind lr_shift_reduce_parse_engine_unit lrp_checker u_lrp_checker (.*);

@@ tb/lr_shift_reduce_parse_engine_unit_tb.sv @@
// Self-checking testbench for the LR shift-reduce parse engine: tables, parses, errors.
module lr_shift_reduce_parse_engine_unit_tb;
    import lrp_pkg::*;

    localparam int N_STATES = DEF_NUM_STATES;
    localparam int N_TERMS  = DEF_NUM_TERMINALS;
    localparam int N_NTERMS = DEF_NUM_NONTERMINALS;
    localparam int N_PRODS  = DEF_NUM_PRODUCTIONS;
    localparam int N_STACK  = DEF_STACK_DEPTH;
    localparam logic [0:0] CFG_END_MARKER = 1'd1;
    localparam int CMD_BAD  = 7;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] state_idx;
        logic [5:0] symbol;
        logic [1:0] kind;
        logic [7:0] value;
        logic [6:0] prod_idx;
        logic [3:0] rhs_len;
    } t_cmd_txn;

    typedef struct {
        t_outcome    outcome;
        logic [15:0] reds;
        logic [7:0]  top;
        logic [8:0]  depth;
    } t_parse_res;

    // Mirror of the parser: tables, stack, step budget, expected results
    class parse_scoreboard;
        logic [9:0]  act_cells [N_STATES*N_TERMS];
        logic [8:0]  goto_cells [N_STATES*N_NTERMS];
        logic [9:0]  prod_cells [N_PRODS];
        logic [7:0]  stack_mem [N_STACK];
        int unsigned sp;
        int unsigned steps;
        bit          idle_parse;
        int unsigned step_limit;
        logic [5:0]  end_marker;
        t_parse_res  pending [$];
        int          errors;

        function new();
            foreach (act_cells[i]) act_cells[i] = '0;
            foreach (goto_cells[i]) goto_cells[i] = '0;
            foreach (prod_cells[i]) prod_cells[i] = '0;
            sp = 0;
            steps = 0;
            idle_parse = 1;
            step_limit = 32'(STEP_LIMIT_RESET);
            end_marker = '0;
            errors = 0;
        endfunction

        function void set_cfg(logic [0:0] idx, logic [15:0] data);
            if (idx == CFG_STEP_LIMIT) step_limit = 32'(data);
            else end_marker = data[5:0];
        endfunction

        function logic [7:0] top_of();
            return (sp == 0) ? 8'd0 : stack_mem[sp-1];
        endfunction

        function bit push(logic [7:0] s);
            if (sp >= N_STACK) return 0;
            stack_mem[sp] = s;
            sp++;
            return 1;
        endfunction

        // One token: reduce until shift, accept or an error
        function t_outcome run_token(logic [5:0] tok, inout logic [15:0] reds);
            logic [9:0] act_entry;
            logic [9:0] prod;
            logic [8:0] g;
            int unsigned len;
            int unsigned lhs;
            forever begin
                if (steps >= step_limit) return OUT_LIMIT;
                steps++;
                act_entry = act_cells[top_of() * N_TERMS + tok];
                case (t_kind'(act_entry[9:8]))
                    KIND_ACCEPT: return OUT_ACCEPT;
                    KIND_ERROR: return OUT_SYNTAX;
                    KIND_SHIFT: return push(act_entry[7:0]) ? OUT_SHIFT : OUT_OVERFLOW;
                    default: begin
                        prod = (act_entry[7:0] < N_PRODS) ? prod_cells[act_entry[7:0]] : '0;
                        len = 32'(prod[3:0]);
                        lhs = 32'(prod[9:4]);
                        if (sp == 0 || sp - 1 < len) return OUT_UNDERFLOW;
                        sp -= len;
                        g = (lhs < N_NTERMS) ? goto_cells[top_of() * N_NTERMS + lhs] : '0;
                        if (!g[8]) return OUT_NOGOTO;
                        if (!push(g[7:0])) return OUT_OVERFLOW;
                        if (reds != 16'hFFFF) reds++;
                    end
                endcase
            end
        endfunction

        function void note(t_cmd_txn t);
            t_parse_res r;
            logic [15:0] reds_cnt;
            r.outcome = OUT_IGNORED;
            r.reds = '0;
            reds_cnt = '0;
            case (t.cmd)
                CMD_BEGIN: begin
                    sp = 0;
                    void'(push(8'd0));
                    steps = 0;
                    idle_parse = 0;
                    r.outcome = OUT_OK;
                end
                CMD_WR_ACT: begin
                    act_cells[t.state_idx * N_TERMS + t.symbol] = {t.kind, t.value};
                    r.outcome = OUT_OK;
                end
                CMD_WR_GOTO: if (t.symbol < N_NTERMS) begin
                    goto_cells[t.state_idx * N_NTERMS + t.symbol] = {t.kind != 0, t.value};
                    r.outcome = OUT_OK;
                end
                CMD_WR_PROD: if (t.symbol < N_NTERMS) begin
                    prod_cells[t.prod_idx] = {t.symbol, t.rhs_len};
                    r.outcome = OUT_OK;
                end
                CMD_TOKEN: if (!idle_parse) begin
                    r.outcome = run_token(t.symbol, reds_cnt);
                    r.reds = reds_cnt;
                    if (r.outcome != OUT_SHIFT) idle_parse = 1;
                end
                default: ;
            endcase
            r.top = top_of();
            r.depth = 9'(sp);
            pending.insert(pending.size(), r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check(t_parse_res got);
            t_parse_res want;
            if (pending.size() == 0) begin
                report("unexpected result, outcome", got.outcome, -1);
                return;
            end
            want = pending.pop_front();
            if (got.outcome !== want.outcome) report("outcome", got.outcome, want.outcome);
            if (got.reds !== want.reds) report("reductions", got.reds, want.reds);
            if (got.top !== want.top) report("top_state", got.top, want.top);
            if (got.depth !== want.depth) report("stack_depth", got.depth, want.depth);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_cmd;
    logic [7:0]  i_state_index;
    logic [5:0]  i_symbol;
    logic [1:0]  i_entry_kind;
    logic [7:0]  i_entry_value;
    logic [6:0]  i_production_index;
    logic [3:0]  i_rhs_length;
    logic        o_done;
    logic [3:0]  o_outcome;
    logic [15:0] o_reductions_done;
    logic [7:0]  o_top_state;
    logic [8:0]  o_stack_depth;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    parse_scoreboard sb;
    int          idle_pct;
    int unsigned cycles = 0;

    lr_shift_reduce_parse_engine_unit dut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Result monitor and run watchdog
    always @(posedge i_clk) begin
        t_parse_res r;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && o_done) begin
            r.outcome = t_outcome'(o_outcome);
            r.reds = o_reductions_done;
            r.top = o_top_state;
            r.depth = o_stack_depth;
            sb.check(r);
        end
    end

    // Drive one command transaction, holding start until the engine takes it
    task automatic send(t_cmd_txn t);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_cmd <= t.cmd;
        i_state_index <= t.state_idx;
        i_symbol <= t.symbol;
        i_entry_kind <= t.kind;
        i_entry_value <= t.value;
        i_production_index <= t.prod_idx;
        i_rhs_length <= t.rhs_len;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        sb.note(t);
        @(posedge i_clk);
    endtask

    task automatic send_fields(int cmd, int st, int sym, int kind, int val, int pi, int len);
        t_cmd_txn t;
        t.cmd = 3'(cmd);
        t.state_idx = 8'(st);
        t.symbol = 6'(sym);
        t.kind = 2'(kind);
        t.value = 8'(val);
        t.prod_idx = 7'(pi);
        t.rhs_len = 4'(len);
        send(t);
    endtask

    // Let the engine drain, then write the step limit and the end marker
    task automatic settle_and_config(logic [15:0] limit, logic [5:0] marker);
        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= CFG_STEP_LIMIT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        sb.set_cfg(CFG_STEP_LIMIT, limit);
        i_cfg_idx <= CFG_END_MARKER;
        i_cfg_data <= {10'd0, marker};
        @(posedge i_clk);
        sb.set_cfg(CFG_END_MARKER, {10'd0, marker});
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // Random transaction aimed at a small grammar so parses go deep
    function automatic t_cmd_txn rand_txn();
        t_cmd_txn t;
        int r;
        bit wide;
        r = $urandom_range(99);
        wide = ($urandom_range(9) == 0);
        t.cmd = 3'($urandom);
        t.state_idx = 8'(wide ? $urandom_range(255) : $urandom_range(7));
        t.symbol = 6'(wide ? $urandom_range(63) : $urandom_range(3));
        t.kind = 2'($urandom);
        t.value = 8'(wide ? $urandom_range(255) : $urandom_range(7));
        t.prod_idx = 7'(wide ? $urandom_range(127) : $urandom_range(7));
        t.rhs_len = 4'(wide ? $urandom_range(15) : $urandom_range(2));
        if (r < 8) t.cmd = CMD_BEGIN;
        else if (r < 30) t.cmd = CMD_WR_ACT;
        else if (r < 40) t.cmd = CMD_WR_GOTO;
        else if (r < 47) t.cmd = CMD_WR_PROD;
        else if (r < 50) t.cmd = 3'($urandom_range(CMD_BAD, CMD_TOKEN + 1));
        else begin
            t.cmd = CMD_TOKEN;
            if ($urandom_range(9) == 0) t.symbol = sb.end_marker;
        end
        return t;
    endfunction

    initial begin
        logic [15:0] limits [4] = '{16'd300, 16'd1, 16'd150, 16'd400};
        int idles [4] = '{0, 53, 53, 37};
        logic [5:0] markers [4] = '{6'd5, 6'd0, 6'd20, 6'd63};
        sb = new();
        idle_pct = 0;
        start = 0;
        i_cmd = '0;
        i_state_index = '0;
        i_symbol = '0;
        i_entry_kind = '0;
        i_entry_value = '0;
        i_production_index = '0;
        i_rhs_length = '0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        settle_and_config(16'hFFFF, 6'd63);

        // Every production entry written so no reduce reads an empty one
        for (int p = 0; p < N_PRODS; p++)
            send_fields(CMD_WR_PROD, 0, p % 4, 0, 0, p, p % 3);
        send_fields(CMD_WR_PROD, 0, 1, 0, 0, 1, 0);   // epsilon rule, lhs 1
        send_fields(CMD_WR_PROD, 0, 0, 0, 0, 2, 2);   // length 2, lhs 0
        send_fields(CMD_WR_PROD, 0, 2, 0, 0, 3, 1);   // length 1, lhs 2

        // Directed: ignored commands and out-of-range writes
        send_fields(CMD_TOKEN, 0, 1, 0, 0, 0, 0);
        send_fields(CMD_BAD, 255, 63, 3, 255, 127, 15);
        send_fields(CMD_WR_GOTO, 0, 40, 1, 9, 0, 0);
        send_fields(CMD_WR_PROD, 0, 33, 0, 0, 127, 15);
        // Shift, reduce, accept
        send_fields(CMD_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(CMD_WR_ACT, 0, 1, KIND_SHIFT, 3, 0, 0);
        send_fields(CMD_TOKEN, 0, 1, 0, 0, 0, 0);
        send_fields(CMD_WR_ACT, 3, 2, KIND_REDUCE, 3, 0, 0);
        send_fields(CMD_WR_GOTO, 0, 2, 1, 4, 0, 0);
        send_fields(CMD_WR_ACT, 4, 2, KIND_ACCEPT, 0, 0, 0);
        send_fields(CMD_TOKEN, 0, 2, 0, 0, 0, 0);
        // Underflow on a long rule
        send_fields(CMD_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(CMD_WR_ACT, 0, 5, KIND_REDUCE, 2, 0, 0);
        send_fields(CMD_TOKEN, 0, 5, 0, 0, 0, 0);
        // Production number past the table, then a missing goto
        send_fields(CMD_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(CMD_WR_ACT, 0, 6, KIND_REDUCE, 200, 0, 0);
        send_fields(CMD_TOKEN, 0, 6, 0, 0, 0, 0);
        // Syntax error on an empty entry
        send_fields(CMD_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(CMD_TOKEN, 0, 9, 0, 0, 0, 0);
        // Epsilon loop fills the stack to overflow
        send_fields(CMD_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(CMD_WR_ACT, 0, 7, KIND_REDUCE, 1, 0, 0);
        send_fields(CMD_WR_GOTO, 0, 1, 2, 0, 0, 0);
        send_fields(CMD_TOKEN, 0, 7, 0, 0, 0, 0);
        // Accept on the end marker
        send_fields(CMD_BEGIN, 0, 0, 0, 0, 0, 0);
        send_fields(CMD_WR_ACT, 0, 63, KIND_ACCEPT, 255, 0, 0);
        send_fields(CMD_TOKEN, 0, 63, 0, 0, 0, 0);

        // Random phases, each opened from an idle engine with new registers
        for (int ph = 0; ph < 4; ph++) begin
            settle_and_config(limits[ph], markers[ph]);
            idle_pct = idles[ph];
            for (int n = 0; n < 72; n++) send(rand_txn());
        end

        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ filelist.f @@
src/lrp_pkg.sv
src/lrp_front.sv
src/lrp_back.sv
src/lr_shift_reduce_parse_engine_unit.sv
src/lrp_checker.sv
tb/lr_shift_reduce_parse_engine_unit_tb.sv
